FILE: rtl/core/bletpg_pkg.sv
// bletpg_pkg: types, pattern codes and lfsr step functions for the
// ble test pdu pattern generator. No dependencies.
`default_nettype none

package bletpg_pkg;

    localparam int POS_W  = 9;
    localparam int LFSR_W = 15;
    localparam int SIZE_W = 9;
    localparam int CODE_W = 3;
    localparam int CFG_W  = 9;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h01ff;

    // pattern codes
    localparam logic [CODE_W-1:0] PAT_PRBS9  = 3'd0;
    localparam logic [CODE_W-1:0] PAT_0F     = 3'd1;
    localparam logic [CODE_W-1:0] PAT_55     = 3'd2;
    localparam logic [CODE_W-1:0] PAT_PRBS15 = 3'd3;
    localparam logic [CODE_W-1:0] PAT_FF     = 3'd4;
    localparam logic [CODE_W-1:0] PAT_00     = 3'd5;
    localparam logic [CODE_W-1:0] PAT_F0     = 3'd6;
    localparam logic [CODE_W-1:0] PAT_AA     = 3'd7;

    // configuration register indexes
    localparam logic CFG_PATTERN = 1'b0;
    localparam logic CFG_SIZE    = 1'b1;

    typedef struct packed {
        logic              active;
        logic [POS_W-1:0]  pos;
        logic [LFSR_W-1:0] lfsr;
    } bletpg_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } bletpg_result_t;

    // eight shifts of the 9-bit sequence, x^9 + x^5 + 1
    function automatic logic [8:0] prbs9_advance(input logic [8:0] seed);
        logic [8:0] s;
        s = seed;
        for (int k = 0; k < 8; k++)
        begin
            s = {s[0] ^ s[4], s[8:1]};
        end
        return s;
    endfunction

    // eight shifts of the 15-bit sequence, x^15 + x^14 + 1
    function automatic logic [14:0] prbs15_advance(input logic [14:0] seed);
        logic [14:0] s;
        s = seed;
        for (int k = 0; k < 8; k++)
        begin
            s = {s[0] ^ s[1], s[14:1]};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bletpg_byte_gen.sv
// bletpg_byte_gen: works out one packet byte and the next packet state
// from the current state and a request word. Uses bletpg_pkg.
`default_nettype none

module bletpg_byte_gen
    import bletpg_pkg::*;
(
    input  wire logic [CODE_W-1:0] pattern_code,
    input  wire logic [SIZE_W-1:0] packet_size,
    input  wire logic              restart,
    input  wire bletpg_state_t     state,
    output bletpg_state_t          state_next,
    output bletpg_result_t         result
);

    logic              eff_active;
    logic [POS_W-1:0]  eff_pos;
    logic [LFSR_W-1:0] eff_lfsr;
    logic [8:0]        lfsr9;
    logic [14:0]       lfsr15;
    logic [7:0]        payload;
    logic [LFSR_W-1:0] lfsr_stepped;
    logic              last;
    logic [7:0]        length_raw;

    // a restart rewinds to byte zero with a fresh seed
    always_comb
    begin
        if (restart)
        begin
            eff_active = (packet_size >= SIZE_W'(2));
            eff_pos    = '0;
            eff_lfsr   = LFSR_SEED;
        end
        else
        begin
            eff_active = state.active;
            eff_pos    = state.pos;
            eff_lfsr   = state.lfsr;
        end
    end

    assign lfsr9      = eff_lfsr[8:0];
    assign lfsr15     = eff_lfsr;
    assign length_raw = packet_size[7:0] - 8'd2;
    assign last       = ({1'b0, eff_pos} + 10'd1) == {1'b0, packet_size};

    always_comb
    begin
        lfsr_stepped = eff_lfsr;
        unique case (pattern_code)
            PAT_PRBS9:
            begin
                payload      = lfsr9[7:0];
                lfsr_stepped = {6'd0, prbs9_advance(lfsr9)};
            end
            PAT_0F:  payload = 8'h0f;
            PAT_55:  payload = 8'h55;
            PAT_PRBS15:
            begin
                payload      = lfsr15[7:0];
                lfsr_stepped = prbs15_advance(lfsr15);
            end
            PAT_FF:  payload = 8'hff;
            PAT_00:  payload = 8'h00;
            PAT_F0:  payload = 8'hf0;
            PAT_AA:  payload = 8'haa;
            default: payload = 8'haa;
        endcase
    end

    always_comb
    begin
        result          = '0;
        state_next.active = eff_active;
        state_next.pos    = eff_pos;
        state_next.lfsr   = eff_lfsr;
        if (eff_active)
        begin
            if (eff_pos >= packet_size)
            begin
                // size shrank under a running packet
                state_next.active = 1'b0;
            end
            else
            begin
                result.valid = 1'b1;
                result.last  = last;
                priority if (eff_pos == POS_W'(0))
                begin
                    result.data = {5'd0, pattern_code};
                end
                else if (eff_pos == POS_W'(1))
                begin
                    result.data = length_raw;
                end
                else
                begin
                    result.data     = payload;
                    state_next.lfsr = lfsr_stepped;
                end
                state_next.active = !last;
                state_next.pos    = eff_pos + POS_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ble_test_pdu_pattern_generator.sv
// ble_test_pdu_pattern_generator: top level, request channel, config
// registers, state registers and a two-word output buffer.
// Uses bletpg_pkg and bletpg_byte_gen.
//
// Usage: each word on the request channel (in_valid/in_ready, field
// restart) asks for one packet byte. restart = 1 opens a new packet and
// answers its pattern code byte; restart = 0 asks for the next byte. Byte
// one is the length (packet_size - 2), the rest is payload from a fixed
// pattern or a prbs9/prbs15 generator. Requests with no packet running, or
// a restart with packet_size below two, give no word on the output.
// The output channel (out_valid/out_ready) carries data_byte and last_byte.
// One request is taken every cycle while in_ready is high. The byte logic
// (eight lfsr shifts flattened into xor terms) sits between the state
// registers and the output register. When the receiver stalls, one more
// word goes into a skid register and in_ready drops only once that
// register is full.
// The user must write configuration (cfg_we/index/data) only while idle.
// Reset: pattern prbs9, size 2, no packet running, output buffer empty.
`default_nettype none

module ble_test_pdu_pattern_generator
    import bletpg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             restart,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            data_byte,
    output logic                  last_byte,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [CODE_W-1:0] pattern_reg;
    logic [SIZE_W-1:0] size_reg;
    bletpg_state_t     state_reg;
    bletpg_state_t     state_next;
    bletpg_result_t    result;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;
    logic       skid_last_reg;

    logic in_fire;
    logic out_fire;
    logic push;

    bletpg_byte_gen u_byte_gen (
        .pattern_code (pattern_reg),
        .packet_size  (size_reg),
        .restart      (restart),
        .state        (state_reg),
        .state_next   (state_next),
        .result       (result)
    );

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign push      = in_fire && result.valid;
    assign out_valid = out_valid_reg;
    assign data_byte = out_data_reg;
    assign last_byte = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PAT_PRBS9;
            size_reg    <= SIZE_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN: pattern_reg <= cfg_data[CODE_W-1:0];
                CFG_SIZE:    size_reg    <= cfg_data[SIZE_W-1:0];
                default:     size_reg    <= size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active <= 1'b0;
            state_reg.pos    <= '0;
            state_reg.lfsr   <= LFSR_SEED;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= result.data;
                out_last_reg <= result.last;
            end
            else
            begin
                skid_data_reg <= result.data;
                skid_last_reg <= result.last;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with output register empty");

    a_last_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (push && result.last) |=> !state_reg.active)
        else $error("packet still running after its last byte");

    a_short_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart && (size_reg < SIZE_W'(2))) |=> !state_reg.active)
        else $error("packet opened with size below two");

    a_no_word_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !restart && !state_reg.active) |-> !result.valid)
        else $error("word produced with no packet running");
`endif

endmodule

`default_nettype wire
